FILE: rtl/tlh_pkg.sv
// Package for the transaction latency histogram: constants, request and status codes.
// Used by the top level, the checker and the testbench; depends on nothing.
package tlh_pkg;
    localparam int PendingEntriesDef = 1024;
    localparam int HistEntriesDef    = 512;
    localparam int MaxBucket         = 63;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_DONE  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_START = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ABSENT   = 2'd3;

    // Histogram key: device, op, bucket.
    typedef struct packed {
        logic [31:0] dev;
        logic [1:0]  op;
        logic [5:0]  bkt;
    } t_hkey;

    // In-flight entry: tag, time, op, device.
    typedef struct packed {
        logic [63:0] tag;
        logic [63:0] tim;
        logic [1:0]  op;
        logic [31:0] dev;
    } t_pend;

    function automatic logic [5:0] floor_log2(input logic [63:0] v);
        logic [5:0] b;
        b = '0;
        for (int k = 1; k < 64; k++) begin
            if (v[k]) b = 6'(k);
        end
        return b;
    endfunction
endpackage

FILE: rtl/transaction_latency_histogram_unit.sv
// Transaction latency histogram: pairs start/done requests by tag, bins latency by log2.
// Each request walks the pending table (one entry a cycle; reads skip it), then the
// histogram key table on a done that found its start or on a read, then the output.
// One request in flight; the next is taken once the output register's result is accepted.
// Reset (synchronous, active low) clears the valid-bit vectors and the controller state;
// memory contents are left as they are and read only behind a valid bit.
module transaction_latency_histogram_unit
    import tlh_pkg::*;
#(
    parameter int PENDING_ENTRIES = tlh_pkg::PendingEntriesDef,
    parameter int HIST_ENTRIES    = tlh_pkg::HistEntriesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_tag,
    input  logic [1:0]  i_op_kind,
    input  logic [31:0] i_device_id,
    input  logic [63:0] i_now_ns,
    input  logic [5:0]  i_query_bucket,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_latency_ns,
    output logic [5:0]  o_bucket,
    output logic [63:0] o_count
);
    localparam int PW = $clog2(PENDING_ENTRIES);
    localparam int HW = $clog2(HIST_ENTRIES);
    localparam int PEW = $bits(t_pend);
    localparam int HKW = $bits(t_hkey);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PSCAN = 3'd1;  // walk pending table
    localparam logic [2:0] S_LAT   = 3'd2;  // compute latency and key
    localparam logic [2:0] S_HSCAN = 3'd3;  // walk histogram key table
    localparam logic [2:0] S_CRD   = 3'd4;  // counter read issued
    localparam logic [2:0] S_CWR   = 3'd5;  // counter update
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_req;
    logic [63:0] r_tag, r_now;
    logic [1:0]  r_op;
    logic [31:0] r_dev;
    logic [5:0]  r_qb;

    logic [PENDING_ENTRIES-1:0] r_pvalid;
    logic [HIST_ENTRIES-1:0]    r_hvalid;

    // Scan counters are one bit wider so they can reach the depth.
    logic [PW:0] r_pidx;   // read address issued
    logic        r_prd;    // read data valid for r_pidx_d
    logic [PW-1:0] r_pidx_d;
    logic        r_pfound, r_pfree_ok;
    logic [PW-1:0] r_pmatch, r_pfree;
    logic [HW:0] r_hidx;
    logic        r_hrd;
    logic [HW-1:0] r_hidx_d;
    logic        r_hfound, r_hfree_ok;
    logic [HW-1:0] r_hmatch, r_hfree;
    t_pend       r_pent;   // matched entry
    t_hkey       r_key;
    logic        r_new;

    logic [1:0]  r_st;
    logic [63:0] r_lat, r_cnt;
    logic [5:0]  r_bkt;

    // Memories.
    logic          p_we;
    logic [PW-1:0] p_wa, p_ra;
    t_pend         p_wd, p_rd;
    logic          k_we;
    logic [HW-1:0] k_wa, k_ra;
    t_hkey         k_wd, k_rd;
    logic          c_we;
    logic [HW-1:0] c_wa, c_ra;
    logic [63:0]   c_wd, c_rd;

    tlh_ram #(.WIDTH(PEW), .DEPTH(PENDING_ENTRIES)) u_pend (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));
    tlh_ram #(.WIDTH(HKW), .DEPTH(HIST_ENTRIES)) u_hkey (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_wa), .i_wdata(k_wd),
        .i_raddr(k_ra), .o_rdata(k_rd));
    tlh_ram #(.WIDTH(64), .DEPTH(HIST_ENTRIES)) u_hcnt (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd));

    // Accept a request only when idle; result register parts the output side.
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_st;
    assign o_latency_ns = r_lat;
    assign o_bucket = r_bkt;
    assign o_count = r_cnt;

    assign p_ra = r_pidx[PW-1:0];
    assign k_ra = r_hidx[HW-1:0];
    assign c_ra = r_hfound ? r_hmatch : r_hfree;

    logic p_last, h_last;
    assign p_last = r_prd && (r_pidx_d == PW'(PENDING_ENTRIES - 1));
    assign h_last = r_hrd && (r_hidx_d == HW'(HIST_ENTRIES - 1));

    // Hit checks on the entry returned this cycle.
    logic p_hit, h_hit;
    assign p_hit = r_prd && r_pvalid[r_pidx_d] && (p_rd.tag == r_tag);
    assign h_hit = r_hrd && r_hvalid[r_hidx_d] && (k_rd == r_key);

    always_comb begin
        n_state = r_state;
        p_we = 1'b0;
        p_wa = r_pfound ? r_pmatch : r_pfree;
        p_wd = '{tag: r_tag, tim: r_now, op: r_op, dev: r_dev};
        k_we = 1'b0;
        k_wa = r_hfree;
        k_wd = r_key;
        c_we = 1'b0;
        c_wa = c_ra;
        c_wd = r_new ? 64'd1 : c_rd + 64'd1;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_PSCAN;
            S_PSCAN: if (p_last || p_hit) begin
                if (r_req == REQ_START) begin
                    n_state = S_OUT;
                    p_we = p_hit || r_pfree_ok ||
                           (r_prd && !r_pvalid[r_pidx_d]);
                    p_wa = p_hit ? r_pidx_d :
                           (r_pfree_ok ? r_pfree : r_pidx_d);
                end else if (r_req == REQ_DONE) begin
                    n_state = p_hit ? S_LAT : S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LAT:   n_state = S_HSCAN;
            S_HSCAN: if (h_last || h_hit) n_state = S_CRD;
            S_CRD:   n_state = S_CWR;
            S_CWR: begin
                n_state = S_OUT;
                if (r_req == REQ_DONE && (r_hfound || r_hfree_ok)) begin
                    c_we = 1'b1;
                    k_we = !r_hfound;
                end
            end
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pvalid <= '0;
            r_hvalid <= '0;
            r_prd    <= 1'b0;
            r_hrd    <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_req <= i_req_type; r_tag <= i_tag; r_op <= i_op_kind;
                    r_dev <= i_device_id; r_now <= i_now_ns; r_qb <= i_query_bucket;
                    r_pidx <= '0; r_prd <= 1'b0;
                    r_pfound <= 1'b0; r_pfree_ok <= 1'b0;
                    r_hfound <= 1'b0; r_hfree_ok <= 1'b0;
                    r_st <= ST_OK; r_lat <= '0; r_bkt <= '0; r_cnt <= '0;
                end
                S_PSCAN: begin
                    // Reads skip the pending table: jump straight to key scan.
                    if (r_req == REQ_READ) begin
                        r_key <= '{dev: r_dev, op: r_op, bkt: r_qb};
                        r_hidx <= '0; r_hrd <= 1'b0;
                        r_state <= S_HSCAN;
                    end else if (r_req != REQ_START && r_req != REQ_DONE) begin
                        r_state <= S_OUT;
                    end else begin
                        // Advance the walk, one read issued a cycle.
                        if (r_pidx != (PW+1)'(PENDING_ENTRIES)) begin
                            r_pidx <= r_pidx + 1'b1;
                            r_pidx_d <= r_pidx[PW-1:0];
                            r_prd <= 1'b1;
                        end else begin
                            r_prd <= 1'b0;
                        end
                        if (r_prd && !r_pvalid[r_pidx_d] && !r_pfree_ok) begin
                            r_pfree <= r_pidx_d; r_pfree_ok <= 1'b1;
                        end
                        if (p_last || p_hit) begin
                            r_prd <= 1'b0;
                            if (r_req == REQ_START) begin
                                if (p_we) r_pvalid[p_wa] <= 1'b1;
                                else r_st <= ST_FULL;
                            end else if (p_hit) begin
                                r_pent <= p_rd; r_pmatch <= r_pidx_d;
                                r_pvalid[r_pidx_d] <= 1'b0;  // free even if hist full
                            end else begin
                                r_st <= ST_NO_START;
                            end
                        end
                    end
                end
                S_LAT: begin
                    r_lat <= r_now - r_pent.tim;
                    r_bkt <= floor_log2(r_now - r_pent.tim);
                    r_key <= '{dev: r_pent.dev, op: r_pent.op,
                               bkt: floor_log2(r_now - r_pent.tim)};
                    r_hidx <= '0; r_hrd <= 1'b0;
                end
                S_HSCAN: begin
                    if (r_hidx != (HW+1)'(HIST_ENTRIES)) begin
                        r_hidx <= r_hidx + 1'b1;
                        r_hidx_d <= r_hidx[HW-1:0];
                        r_hrd <= 1'b1;
                    end else begin
                        r_hrd <= 1'b0;
                    end
                    if (r_hrd && !r_hvalid[r_hidx_d] && !r_hfree_ok) begin
                        r_hfree <= r_hidx_d; r_hfree_ok <= 1'b1;
                    end
                    if (h_hit) begin
                        r_hfound <= 1'b1; r_hmatch <= r_hidx_d;
                    end
                    if (h_last || h_hit) r_hrd <= 1'b0;
                end
                S_CRD: r_new <= !r_hfound;
                S_CWR: begin
                    if (r_req == REQ_DONE) begin
                        if (r_hfound || r_hfree_ok) begin
                            r_cnt <= c_wd;
                            if (!r_hfound) r_hvalid[r_hfree] <= 1'b1;
                        end else begin
                            r_st <= ST_ABSENT;
                        end
                    end else if (r_hfound) begin
                        r_cnt <= c_rd;
                    end else begin
                        r_st <= ST_ABSENT;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/tlh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: verif/tlh_checker.sv
// Checker for the transaction latency histogram unit: watches both channels,
// predicts each result and compares it. Depends on tlh_pkg for status and request codes and table depths.
module tlh_checker
    import tlh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_tag,
    input  logic [1:0]  i_op_kind,
    input  logic [31:0] i_device_id,
    input  logic [63:0] i_now_ns,
    input  logic [5:0]  i_query_bucket,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_status,
    input  logic [63:0] i_latency_ns,
    input  logic [5:0]  i_bucket,
    input  logic [63:0] i_count,
    output int          o_errors,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int InflightSlots = PendingEntriesDef;
    localparam int CounterSlots  = HistEntriesDef;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] latency;
        logic [5:0]  bkt;
        logic [63:0] count;
    } t_latency_result;

    // in-flight requests keyed by tag, counters keyed by {dev, op, bucket}
    logic [63:0] start_time [logic [63:0]];
    logic [1:0]  start_op   [logic [63:0]];
    logic [31:0] start_dev  [logic [63:0]];
    logic [63:0] bin_count  [logic [39:0]];

    t_latency_result expected_results[$];
    int errors;

    assign o_errors      = errors;
    assign o_outstanding = expected_results.size();

    function automatic logic [5:0] log2_bin(input logic [63:0] v);
        logic [5:0] b;
        b = '0;
        for (int k = 63; k >= 1; k--) begin
            if (v[k] && b == 0) b = 6'(k);
        end
        return b;
    endfunction

    function automatic t_latency_result apply_request(input logic [1:0] req,
            input logic [63:0] tag, input logic [1:0] op, input logic [31:0] dev,
            input logic [63:0] now, input logic [5:0] qb);
        t_latency_result r;
        logic [39:0] key;
        r = '0;
        r.status = ST_OK;
        case (req)
            REQ_START: begin
                if (!start_time.exists(tag) && start_time.num() >= InflightSlots) begin
                    r.status = ST_FULL;
                end else begin
                    start_time[tag] = now;
                    start_op[tag]   = op;
                    start_dev[tag]  = dev;
                end
            end
            REQ_DONE: begin
                if (!start_time.exists(tag)) begin
                    r.status = ST_NO_START;
                end else begin
                    r.latency = now - start_time[tag];
                    r.bkt     = log2_bin(r.latency);
                    key       = {start_dev[tag], start_op[tag], r.bkt};
                    if (!bin_count.exists(key) && bin_count.num() < CounterSlots)
                        bin_count[key] = '0;
                    if (bin_count.exists(key)) begin
                        bin_count[key] = bin_count[key] + 64'd1;
                        r.count = bin_count[key];
                    end else begin
                        r.status = ST_ABSENT;
                    end
                    start_time.delete(tag);
                    start_op.delete(tag);
                    start_dev.delete(tag);
                end
            end
            REQ_READ: begin
                key = {dev, op, qb};
                if (bin_count.exists(key)) r.count = bin_count[key];
                else r.status = ST_ABSENT;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        t_latency_result want;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", {62'd0, i_status}, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", {62'd0, i_status}, {62'd0, want.status});
                    if (i_latency_ns !== want.latency)
                        report_mismatch("latency_ns", i_latency_ns, want.latency);
                    if (i_bucket !== want.bkt)
                        report_mismatch("bucket", {58'd0, i_bucket}, {58'd0, want.bkt});
                    if (i_count !== want.count)
                        report_mismatch("count", i_count, want.count);
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(apply_request(i_req_type, i_tag, i_op_kind,
                    i_device_id, i_now_ns, i_query_bucket));
        end
    end
endmodule

FILE: verif/tb.sv
// Top of the testbench: clock, reset, request stimulus, result back-pressure, verdict.
// Depends on tlh_pkg, the transaction_latency_histogram_unit RTL and tlh_checker.
module tb
    import tlh_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam int InflightSlots = PendingEntriesDef;
    localparam int HoldOffCycles = 3000;
    // a request can take a full pending scan plus a full key scan
    localparam int DrainCycles   = 2 * (PendingEntriesDef + HistEntriesDef) + 50;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [63:0] i_tag = '0;
    logic [1:0]  i_op_kind = '0;
    logic [31:0] i_device_id = '0;
    logic [63:0] i_now_ns = '0;
    logic [5:0]  i_query_bucket = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_latency_ns;
    logic [5:0]  o_bucket;
    logic [63:0] o_count;

    int errors;
    int outstanding;
    bit hold_results = 1'b0;
    int burst_left = 0;

    // stimulus-side view of live tags, used only to steer requests toward hits
    logic [63:0] live_tag[$];
    logic [63:0] live_time[$];
    logic [31:0] done_dev[$];
    logic [1:0]  done_op[$];
    logic [5:0]  done_bin[$];

    always #4 i_clk = ~i_clk;

    transaction_latency_histogram_unit dut (.*);

    tlh_checker checker_i (
        .i_clk, .i_rst_n,
        .i_req_valid(i_valid), .i_req_ready(o_ready),
        .i_req_type, .i_tag, .i_op_kind, .i_device_id, .i_now_ns, .i_query_bucket,
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_status(o_status), .i_latency_ns(o_latency_ns), .i_bucket(o_bucket),
        .i_count(o_count),
        .o_errors(errors), .o_outstanding(outstanding)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one request and hold it until the block takes it; keep valid high
    // inside a burst, drop it for a random gap once the burst runs out.
    task automatic send_request(input logic [1:0] req, input logic [63:0] tag,
            input logic [1:0] op, input logic [31:0] dev, input logic [63:0] now,
            input logic [5:0] qb);
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_tag          <= tag;
        i_op_kind      <= op;
        i_device_id    <= dev;
        i_now_ns       <= now;
        i_query_bucket <= qb;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 6);
        end
    endtask

    // Pair a start with a done after a chosen latency.
    task automatic start_done(input logic [63:0] tag, input logic [1:0] op,
            input logic [31:0] dev, input logic [63:0] t0, input logic [63:0] lat);
        send_request(REQ_START, tag, op, dev, t0, $urandom_range(0, 63));
        send_request(REQ_DONE, tag, $urandom_range(0, 3), $urandom, t0 + lat,
            $urandom_range(0, 63));
    endtask

    // Pause the sender until every expected result is back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Result side: runs of always-ready, random stalls, and mostly-stalled,
    // plus one long hold-off on request from the sender.
    initial begin
        int run_len;
        int style;
        @(posedge i_rst_n);
        forever begin
            if (hold_results) begin
                i_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                run_len = $urandom_range(1, 60);
                style = $urandom_range(0, 2);
                repeat (run_len) begin
                    case (style)
                        0: i_ready <= 1'b1;
                        1: i_ready <= $urandom_range(0, 1);
                        default: i_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #300ms;
        $display("transaction_latency_histogram_unit verification failed");
        $finish;
    end

    initial begin
        logic [63:0] tag;
        logic [63:0] t0;
        logic [63:0] lat;
        int pick;
        int sh;
        int matched;
        int idx;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: read before anything exists, unknown done
        send_request(REQ_READ, '0, 2'd0, '0, '0, 6'd0);
        send_request(REQ_DONE, 64'h1234, 2'd0, '0, 64'd10, 6'd0);
        // a done one ns after its start and a done at its start time, both land in bin zero
        start_done('0, 2'd0, '0, '0, 64'd1);
        start_done('1, 2'd2, '1, 64'd5, 64'd0);
        // timestamp wraps across zero
        start_done(64'hA5A5, 2'd1, 32'd7, '1, 64'd3);
        // overwrite of a live tag, then the top bin
        send_request(REQ_START, 64'hB0B0, 2'd3, 32'd9, '0, 6'd0);
        start_done(64'hB0B0, 2'd1, 32'd9, 64'd100, 64'h8000_0000_0000_0000);
        start_done(64'hC0C0, 2'd0, 32'd11, '0, '1);
        send_request(REQ_READ, '0, 2'd0, '0, '0, 6'd0);
        send_request(REQ_READ, '0, 2'd2, '1, '0, 6'd0);
        send_request(REQ_READ, '0, 2'd1, 32'd9, '0, 6'd63);
        send_request(REQ_RESERVED, rand64(), 2'd3, $urandom, rand64(), 6'd63);
        send_request(REQ_DONE, '1, 2'd0, '0, '0, 6'd0);
        // same key twice, counter climbs
        start_done(64'hD0D0, 2'd0, '0, 64'd50, 64'd1);
        start_done(64'hD0D0, 2'd0, '0, 64'd70, 64'd1);
        send_request(REQ_READ, '0, 2'd0, '0, '0, 6'd0);

        // fill the in-flight table, each entry with its own device
        for (int k = 0; k < InflightSlots; k++) begin
            tag = rand64();
            t0 = rand64();
            live_tag.push_back(tag);
            live_time.push_back(t0);
            send_request(REQ_START, tag, $urandom_range(0, 3), 32'(1000 + k), t0,
                $urandom_range(0, 63));
        end
        // table full: new tags are dropped, a live tag still overwrites
        repeat (4) send_request(REQ_START, rand64(), $urandom_range(0, 3), $urandom,
            rand64(), 6'd0);
        t0 = rand64();
        live_time[5] = t0;
        send_request(REQ_START, live_tag[5], 2'd2, 32'd1005, t0, 6'd0);
        drain();

        // hold the results off while requests keep coming
        hold_results = 1'b1;
        matched = 0;
        while (matched < 560 && live_tag.size() > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                idx = $urandom_range(0, live_tag.size() - 1);
                sh = $urandom_range(0, 63);
                lat = rand64() >> sh;
                send_request(REQ_DONE, live_tag[idx], $urandom_range(0, 3), $urandom,
                    live_time[idx] + lat, $urandom_range(0, 63));
                done_bin.push_back(6'(63 - sh));
                live_tag.delete(idx);
                live_time.delete(idx);
                matched++;
            end else if (pick < 68) begin
                send_request(REQ_DONE, rand64(), $urandom_range(0, 3), $urandom, rand64(),
                    $urandom_range(0, 63));
            end else if (pick < 80) begin
                tag = rand64();
                t0 = rand64();
                if (live_tag.size() < InflightSlots) begin
                    live_tag.push_back(tag);
                    live_time.push_back(t0);
                end
                send_request(REQ_START, tag, $urandom_range(0, 3),
                    ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 7)) : $urandom,
                    t0, $urandom_range(0, 63));
            end else if (pick < 95) begin
                // aim reads at the filled-table devices and completed bins, sometimes anywhere
                if (done_bin.size() > 0 && $urandom_range(0, 3) != 0)
                    send_request(REQ_READ, rand64(), $urandom_range(0, 3),
                        32'(1000 + $urandom_range(0, InflightSlots - 1)), rand64(),
                        done_bin[$urandom_range(0, done_bin.size() - 1)]);
                else
                    send_request(REQ_READ, rand64(), $urandom_range(0, 3),
                        32'($urandom_range(0, 7)), rand64(), $urandom_range(0, 63));
            end else begin
                send_request(REQ_RESERVED, rand64(), $urandom_range(0, 3), $urandom,
                    rand64(), $urandom_range(0, 63));
            end
        end

        drain();
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("transaction_latency_histogram_unit verification clean");
        end else begin
            $display("transaction_latency_histogram_unit verification failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/tlh_pkg.sv
rtl/tlh_ram.sv
rtl/transaction_latency_histogram_unit.sv
verif/tlh_checker.sv
verif/tb.sv
